@@ rtl/mrt_pkg.sv @@
// Shared types and codes for the missing-range table.
package mrt_pkg;
   localparam logic [1:0] MODE_ADD    = 2'd0;
   localparam logic [1:0] MODE_REMOVE = 2'd1;
   localparam logic [1:0] MODE_READ   = 2'd2;
   localparam logic [1:0] MODE_UNUSED = 2'd3;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [1:0] ST_FULL      = 2'd2;
   localparam logic [1:0] ST_BAD       = 2'd3;

   localparam int COUNT_W = 7;
   localparam int TOTAL_W = 39;

   // what goes into the table on a write
   typedef enum logic [1:0] {WR_CARRY, WR_FIRST_UP, WR_LAST_DN, WR_RDATA} wr_sel_type;
   // what the carry register takes next
   typedef enum logic [1:0] {CARRY_KEEP, CARRY_NEW, CARRY_SPLIT, CARRY_RDATA} carry_sel_type;

   // controller to datapath
   typedef struct packed {
      logic          load;      // capture request
      logic          ptr_clr;   // clear scan pointer
      logic          ptr_inc;   // advance scan pointer
      logic          addr_next; // address entry ptr+1
      logic          wr_en;     // write table at current address
      wr_sel_type    wr_sel;
      carry_sel_type carry_sel;
      logic          count_up;
      logic          count_dn;
      logic          total_add; // add span of the new range
      logic          total_dec; // one value taken out
      logic          respond;   // pulse result
      logic [1:0]    status;
   } mrt_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic [1:0] mode;
      logic bad_range;
      logic full;
      logic scan_end;   // pointer reached count
      logic last_move;  // pointer+1 reached count
      logic add_stop;   // entry first > add high
      logic hit;        // entry holds remove value
      logic hit_first;
      logic hit_last;
      logic idx_ok;
   } mrt_stat_type;
endpackage

@@ rtl/missing_range_table_unit.sv @@
// Top level of the missing-range table.
// Reads and rejected commands pass through S_DECIDE and S_RESP; add and remove also
// scan (S_SCAN_RD/S_SCAN_EV) and move entries (S_INS/S_INS_NX or S_DEL_RD/S_DEL_WR).
// Throughput: one command at a time; busy drops in the strobe cycle, so the next
// transfer can be taken at the edge that ends it. The receiver cannot stall.
// Synchronous reset empties the table (count and total to zero).
module missing_range_table_unit import mrt_pkg::*; #(
   parameter int MAX_RANGES = 64
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  logic [1:0]   req_mode,
   input  logic [31:0]  req_add_low,
   input  logic [31:0]  req_add_high,
   input  logic [31:0]  req_remove_value,
   input  logic [5:0]   req_entry_index,
   output logic         rsp_valid,
   output logic [1:0]   rsp_status,
   output logic [6:0]   rsp_range_count,
   output logic [38:0]  rsp_missing_total,
   output logic [31:0]  rsp_entry_low,
   output logic [31:0]  rsp_entry_high
);
   mrt_cmd_type cmd;
   mrt_stat_type stat;

   mrt_ctrl u_ctrl (.clock, .reset, .start, .busy, .stat, .cmd, .rsp_valid);
   mrt_datapath #(.MAX_RANGES(MAX_RANGES)) u_dp (
      .clock, .reset, .req_mode, .req_add_low, .req_add_high, .req_remove_value,
      .req_entry_index, .cmd, .stat, .rsp_status, .rsp_range_count,
      .rsp_missing_total, .rsp_entry_low, .rsp_entry_high);
endmodule

@@ rtl/mrt_ram.sv @@
// Generic single-port RAM with registered read.
module mrt_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) mem[addr] <= wr_data;
      rd_data <= mem[addr];
   end
endmodule

@@ rtl/mrt_datapath.sv @@
// Datapath: table memory, pointers, counters and result registers.
module mrt_datapath import mrt_pkg::*; #(
   parameter int MAX_RANGES = 64
) (
   input  logic         clock,
   input  logic         reset,
   input  logic [1:0]   req_mode,
   input  logic [31:0]  req_add_low,
   input  logic [31:0]  req_add_high,
   input  logic [31:0]  req_remove_value,
   input  logic [5:0]   req_entry_index,
   input  mrt_cmd_type  cmd,
   output mrt_stat_type stat,
   output logic [1:0]   rsp_status,
   output logic [COUNT_W-1:0] rsp_range_count,
   output logic [TOTAL_W-1:0] rsp_missing_total,
   output logic [31:0]  rsp_entry_low,
   output logic [31:0]  rsp_entry_high
);
   localparam int AW = $clog2(MAX_RANGES);
   localparam int CW = $clog2(MAX_RANGES + 1);

   logic [1:0]  mode_ff;
   logic [31:0] lo_ff, hi_ff, rv_ff;
   logic [5:0]  idx_ff;
   logic [CW-1:0] count_ff, count_in, ptr_ff, ptr_in;
   logic [TOTAL_W-1:0] total_ff, total_in;
   logic [63:0] carry_ff, carry_in;  // entry rippling up during an insert
   logic [63:0] rd_data, wr_data;
   logic [AW-1:0] addr;
   logic [31:0] f, l, rv_dn, rv_up;
   logic [32:0] span;
   logic [1:0]  status_ff;
   logic [COUNT_W-1:0] range_count_ff;
   logic [TOTAL_W-1:0] missing_total_ff;
   logic [31:0] entry_low_ff, entry_high_ff;

   assign f = rd_data[63:32];
   assign l = rd_data[31:0];
   assign rv_dn = rv_ff - 32'd1;
   assign rv_up = rv_ff + 32'd1;
   assign span = {1'b0, hi_ff} - {1'b0, lo_ff} + 33'd1;

   always_comb begin
      ptr_in = ptr_ff;
      if (cmd.ptr_clr) ptr_in = '0;
      else if (cmd.ptr_inc) ptr_in = ptr_ff + CW'(1);
   end

   always_comb begin
      if (mode_ff == MODE_READ) addr = AW'(idx_ff);
      else if (cmd.addr_next) addr = AW'(ptr_ff + CW'(1));
      else addr = AW'(ptr_ff);
   end

   always_comb begin
      case (cmd.wr_sel)
         WR_CARRY:    wr_data = carry_ff;
         WR_FIRST_UP: wr_data = {rv_up, l};
         WR_LAST_DN:  wr_data = {f, rv_dn};
         WR_RDATA:    wr_data = rd_data;
         default:     wr_data = carry_ff;
      endcase
   end

   always_comb begin
      case (cmd.carry_sel)
         CARRY_KEEP:  carry_in = carry_ff;
         CARRY_NEW:   carry_in = {lo_ff, hi_ff};
         CARRY_SPLIT: carry_in = {rv_up, l};
         CARRY_RDATA: carry_in = rd_data;
         default:     carry_in = carry_ff;
      endcase
   end

   always_comb begin
      count_in = count_ff;
      total_in = total_ff;
      if (cmd.count_up) count_in = count_ff + CW'(1);
      else if (cmd.count_dn) count_in = count_ff - CW'(1);
      if (cmd.total_add) total_in = total_ff + TOTAL_W'(span);
      else if (cmd.total_dec) total_in = total_ff - TOTAL_W'(1);
   end

   // read before write on the same address: rd_data gives the old entry
   mrt_ram #(.WIDTH(64), .DEPTH(MAX_RANGES)) u_ram (
      .clock(clock), .wr_en(cmd.wr_en), .addr(addr),
      .wr_data(wr_data), .rd_data(rd_data));

   assign stat.mode      = mode_ff;
   assign stat.bad_range = hi_ff < lo_ff;
   assign stat.full      = 32'(count_ff) >= 32'(MAX_RANGES);
   assign stat.scan_end  = ptr_ff >= count_ff;
   assign stat.last_move = (CW+1)'(ptr_ff) + (CW+1)'(1) >= (CW+1)'(count_ff);
   assign stat.add_stop  = f > hi_ff;
   assign stat.hit       = rv_ff >= f && rv_ff <= l;
   assign stat.hit_first = f == rv_ff;
   assign stat.hit_last  = l == rv_ff;
   assign stat.idx_ok    = 32'(idx_ff) < 32'(count_ff);

   assign rsp_status        = status_ff;
   assign rsp_range_count   = range_count_ff;
   assign rsp_missing_total = missing_total_ff;
   assign rsp_entry_low     = entry_low_ff;
   assign rsp_entry_high    = entry_high_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff <= req_mode; lo_ff <= req_add_low; hi_ff <= req_add_high;
         rv_ff <= req_remove_value; idx_ff <= req_entry_index;
      end
      carry_ff <= carry_in;
      if (cmd.respond) begin
         status_ff <= cmd.status;
         range_count_ff <= COUNT_W'(count_ff);
         missing_total_ff <= total_ff;
         entry_low_ff <= (mode_ff == MODE_READ && cmd.status == ST_OK) ? f : '0;
         entry_high_ff <= (mode_ff == MODE_READ && cmd.status == ST_OK) ? l : '0;
      end
      if (reset) begin
         count_ff <= '0; total_ff <= '0; ptr_ff <= '0;
      end else begin
         count_ff <= count_in; total_ff <= total_in; ptr_ff <= ptr_in;
      end
   end
endmodule

@@ rtl/mrt_ctrl.sv @@
// Controller state machine sequencing scan and shift of the table.
module mrt_ctrl import mrt_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  mrt_stat_type stat,
   output mrt_cmd_type  cmd,
   output logic         rsp_valid
);
   typedef enum logic [3:0] {
      S_IDLE, S_DECIDE, S_SCAN_RD, S_SCAN_EV, S_INS, S_INS_NX,
      S_DEL_RD, S_DEL_WR, S_RESP
   } state_type;
   state_type state_ff, state_in;
   logic [1:0] status_ff, status_in;
   logic valid_ff;

   assign busy = state_ff != S_IDLE;
   assign rsp_valid = valid_ff;

   always_comb begin
      cmd = '0;
      cmd.wr_sel = WR_CARRY;
      cmd.carry_sel = CARRY_KEEP;
      state_in = state_ff;
      status_in = status_ff;
      case (state_ff)
         S_IDLE: if (start) begin
            cmd.load = 1'b1;
            cmd.ptr_clr = 1'b1;
            state_in = S_DECIDE;
         end
         S_DECIDE: begin
            state_in = S_RESP;
            case (stat.mode)
               MODE_READ: status_in = stat.idx_ok ? ST_OK : ST_BAD;
               MODE_ADD: begin
                  if (stat.bad_range) status_in = ST_BAD;
                  else if (stat.full) status_in = ST_FULL;
                  else begin
                     cmd.carry_sel = CARRY_NEW;
                     state_in = S_SCAN_RD;
                  end
               end
               MODE_REMOVE: state_in = S_SCAN_RD;
               default: status_in = ST_BAD;
            endcase
         end
         S_SCAN_RD: begin
            if (!stat.scan_end) state_in = S_SCAN_EV;
            else if (stat.mode == MODE_ADD) state_in = S_INS;
            else begin
               status_in = ST_NOT_FOUND;
               state_in = S_RESP;
            end
         end
         S_SCAN_EV: begin
            if (stat.mode == MODE_ADD) begin
               if (stat.add_stop) state_in = S_INS;
               else begin
                  cmd.ptr_inc = 1'b1;
                  state_in = S_SCAN_RD;
               end
            end else if (!stat.hit) begin
               cmd.ptr_inc = 1'b1;
               state_in = S_SCAN_RD;
            end else if (stat.hit_first && stat.hit_last) begin
               state_in = S_DEL_RD;
            end else if (stat.hit_first || stat.hit_last) begin
               cmd.wr_en = 1'b1;
               cmd.wr_sel = stat.hit_first ? WR_FIRST_UP : WR_LAST_DN;
               cmd.total_dec = 1'b1;
               status_in = ST_OK;
               state_in = S_RESP;
            end else if (stat.full) begin
               status_in = ST_FULL;
               state_in = S_RESP;
            end else begin
               // split: lower part stays, upper part ripples in behind it
               cmd.wr_en = 1'b1;
               cmd.wr_sel = WR_LAST_DN;
               cmd.carry_sel = CARRY_SPLIT;
               cmd.ptr_inc = 1'b1;
               state_in = S_INS;
            end
         end
         S_INS: begin
            cmd.wr_en = 1'b1;
            if (stat.scan_end) begin
               cmd.count_up = 1'b1;
               cmd.total_add = stat.mode == MODE_ADD;
               cmd.total_dec = stat.mode != MODE_ADD;
               status_in = ST_OK;
               state_in = S_RESP;
            end else state_in = S_INS_NX;
         end
         S_INS_NX: begin
            cmd.carry_sel = CARRY_RDATA;
            cmd.ptr_inc = 1'b1;
            state_in = S_INS;
         end
         S_DEL_RD: begin
            if (stat.last_move) begin
               cmd.count_dn = 1'b1;
               cmd.total_dec = 1'b1;
               status_in = ST_OK;
               state_in = S_RESP;
            end else begin
               cmd.addr_next = 1'b1;
               state_in = S_DEL_WR;
            end
         end
         S_DEL_WR: begin
            cmd.wr_en = 1'b1;
            cmd.wr_sel = WR_RDATA;
            cmd.ptr_inc = 1'b1;
            state_in = S_DEL_RD;
         end
         S_RESP: begin
            cmd.respond = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
      cmd.status = status_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; status_ff <= ST_OK; valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         status_ff <= status_in;
         valid_ff <= cmd.respond;
      end
   end

`ifndef NO_ASSERTIONS
   a_resp_once: assert property (@(posedge clock) disable iff (reset)
      valid_ff |=> !valid_ff) else $error("double response");
   a_resp_idle: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> !busy) else $error("busy during result");
   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> busy) else $error("not busy after load");
   a_count_dir: assert property (@(posedge clock) disable iff (reset)
      !(cmd.count_up && cmd.count_dn)) else $error("count up and down together");
`endif
endmodule
